// ===== hdl/block_record_lookup_core_assert.svh =====
// Assertion macros used by the record lookup RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef BLOCK_RECORD_LOOKUP_CORE_ASSERT_SVH
`define BLOCK_RECORD_LOOKUP_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define BRL_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define BRL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/brl_pkg.sv =====
// Shared types and codes for the block record lookup core.
// No dependencies; imported by every module of the block except brl_ram.
`timescale 1ns / 1ps

package brl_pkg;

    localparam int SIZE_W = 10;
    localparam int IDX_W  = 16;
    localparam int LEN_W  = 16;
    localparam int WORD_W = 64;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_KEY   = 2'd1;
    localparam logic [1:0] MODE_VALUE = 2'd2;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 10'd512;
    localparam logic [SIZE_W-1:0] HDR_BYTES        = 10'd4;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_KEY,
        OP_VALUE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [8:0]       addr;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] word;
        logic [3:0]        byte_count;
        logic [LEN_W-1:0]  field_length;
        logic              last;
        logic [1:0]        status;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_CHECK,
        S_LEN,
        S_SUM,
        S_POS,
        S_TAKE,
        S_DATA
    } bstate_t;

endpackage

// ===== hdl/block_record_lookup_core.sv =====
// Top level of the block record lookup core: config register, front end,
// request queue and back end. Depends on brl_pkg, brl_front, brl_fifo, brl_back.
`timescale 1ns / 1ps

// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// request   | start, busy             | mode, byte_addr, data_byte, record_index
// result    | result_strobe           | kind, word, byte_count, field_length, last, status
// config    | cfg_valid, cfg_ready    | cfg_data (valid block length)
//
// A request is taken when start is high and busy is low; busy rises only when the
// QUEUE_DEPTH-entry request queue is full. The back end runs one request at a time:
// a load writes one byte to the store; a query reads the header, the length of its
// entry, the lengths before it and then its record through the single read port of
// the byte store (one byte per cycle, registered read data); a failing query ends early.
// Each result is shown for one cycle under result_strobe and cannot be held off.
// Reset clears the queue, the sequencer and sets the block length to 512; the store is
// not cleared and must be loaded before it is queried.

module block_record_lookup_core #(
    parameter int BLOCK_BYTES = 512,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 mode,
    input  logic [8:0]                 byte_addr,
    input  logic [7:0]                 data_byte,
    input  logic [brl_pkg::IDX_W-1:0]  record_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [brl_pkg::SIZE_W-1:0] cfg_data,
    output logic                       result_strobe,
    output logic                       kind,
    output logic [brl_pkg::WORD_W-1:0] word,
    output logic [3:0]                 byte_count,
    output logic [brl_pkg::LEN_W-1:0]  field_length,
    output logic                       last,
    output logic [1:0]                 status
);

    import brl_pkg::*;

    logic [SIZE_W-1:0] blk_len_reg, blk_len_next;
    logic              q_full, q_empty, push, pop;
    cmd_t              push_item, pop_item;
    res_t              res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        blk_len_next = blk_len_reg;
        if (cfg_valid && cfg_ready)
        begin
            blk_len_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg <= BLOCK_SIZE_RESET;
        end
        else
        begin
            blk_len_reg <= blk_len_next;
        end
    end

    brl_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .byte_addr    (byte_addr),
        .data_byte    (data_byte),
        .record_index (record_index),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    brl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    brl_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_len    (blk_len_reg),
        .q_item     (pop_item),
        .q_empty    (q_empty),
        .pop        (pop),
        .res_strobe (result_strobe),
        .res        (res)
    );

    assign kind         = res.kind;
    assign word         = res.word;
    assign byte_count   = res.byte_count;
    assign field_length = res.field_length;
    assign last         = res.last;
    assign status       = res.status;

endmodule

// ===== hdl/brl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/brl_front.sv =====
// Front end: takes requests, classifies them and drops the ones with no effect.
// Depends on brl_pkg; feeds brl_fifo.
`timescale 1ns / 1ps

module brl_front #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic [8:0]                byte_addr,
    input  logic [7:0]                data_byte,
    input  logic [brl_pkg::IDX_W-1:0] record_index,
    input  logic                      q_full,
    output logic                      push,
    output brl_pkg::cmd_t             push_item
);

    import brl_pkg::*;

    logic keep;
    op_t  op;

    always_comb
    begin
        keep = 1'b0;
        op   = OP_LOAD;
        case (mode)
            MODE_LOAD:
            begin
                op   = OP_LOAD;
                // loads beyond the store are dropped here
                keep = ({1'b0, byte_addr} < SIZE_W'(BLOCK_BYTES));
            end
            MODE_KEY:
            begin
                op   = OP_KEY;
                keep = 1'b1;
            end
            MODE_VALUE:
            begin
                op   = OP_VALUE;
                keep = 1'b1;
            end
            default:
            begin
                op   = OP_LOAD;
                keep = 1'b0;
            end
        endcase
    end

    assign busy           = q_full;
    assign push           = start && !q_full && keep;
    assign push_item.op   = op;
    assign push_item.addr = byte_addr;
    assign push_item.data = data_byte;
    assign push_item.idx  = record_index;

endmodule

// ===== hdl/brl_fifo.sv =====
// Short request queue between the front end and the back end.
// Depends on brl_pkg for the request type.
`timescale 1ns / 1ps

module brl_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  brl_pkg::cmd_t push_item,
    input  logic          pop,
    output brl_pkg::cmd_t pop_item,
    output logic          empty,
    output logic          full
);

    import brl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == CNT_W'(0));
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/brl_back.sv =====
// Back end: executes loads and walks the block for key and value queries.
// Depends on brl_pkg, brl_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "block_record_lookup_core_assert.svh"

module brl_back #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [brl_pkg::SIZE_W-1:0] blk_len,
    input  brl_pkg::cmd_t              q_item,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       res_strobe,
    output brl_pkg::res_t              res
);

    import brl_pkg::*;

    localparam int ADDR_W = $clog2(BLOCK_BYTES);
    localparam int BASE_W = 19;
    localparam int OFF_W  = 24;
    localparam int POS_W  = 25;

    bstate_t             state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   table_reg, table_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [SIZE_W-1:0]   pos_reg, pos_next;
    logic [SIZE_W-1:0]   avail_reg, avail_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [SIZE_W-1:0]   iss_left_reg, iss_left_next;
    logic [SIZE_W-1:0]   recv_left_reg, recv_left_next;
    logic [2:0]          lane_reg, lane_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic                rvld_reg;
    logic                res_strobe_reg, res_strobe_next;
    res_t                res_reg, res_next;

    logic [SIZE_W-1:0]   sz;
    logic                streaming, issue, last_byte, is_query;
    logic [7:0]          rbyte;
    logic [WORD_W-1:0]   acc_ins;
    logic [IDX_W-1:0]    hdr_count, hdr_kblob;
    logic [17:0]         tbl;
    logic [BASE_W-1:0]   entry_addr, entry_end, base_full;
    logic                idx_past, entry_out;
    logic [POS_W-1:0]    pos_full;
    logic                pos_out;
    logic [SIZE_W-1:0]   take, n_key, total;

    assign sz = (blk_len > SIZE_W'(BLOCK_BYTES)) ? SIZE_W'(BLOCK_BYTES) : blk_len;

    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign is_query  = (q_item.op != OP_LOAD);
    assign streaming = (state_reg inside {S_HDR, S_LEN, S_SUM, S_DATA});
    assign issue     = streaming && (iss_left_reg != '0);
    assign last_byte = rvld_reg && (recv_left_reg == SIZE_W'(1));
    assign acc_ins   = acc_reg | ({56'd0, rbyte} << {lane_reg, 3'b000});

    brl_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (pop && (q_item.op == OP_LOAD)),
        .waddr (q_item.addr[ADDR_W-1:0]),
        .wdata (q_item.data),
        .re    (issue),
        .raddr (ptr_reg),
        .rdata (rbyte)
    );

    // header checks, evaluated while in S_CHECK
    always_comb
    begin
        hdr_count  = acc_reg[15:0];
        hdr_kblob  = acc_reg[31:16];
        tbl        = kind_reg ? (18'd4 + {1'b0, hdr_count, 1'b0}) : 18'd4;
        entry_addr = {1'b0, tbl} + {2'b00, idx_reg, 1'b0};
        entry_end  = entry_addr + BASE_W'(2);
        idx_past   = (idx_reg >= hdr_count);
        entry_out  = (entry_end > BASE_W'(sz));
        base_full  = BASE_W'(4) + {1'b0, hdr_count, 2'b00}
                   + (kind_reg ? {3'b000, hdr_kblob} : BASE_W'(0));
    end

    // record position and clipping
    always_comb
    begin
        pos_full = POS_W'(base_reg) + POS_W'(off_reg);
        pos_out  = (pos_full > POS_W'(sz));
        take     = (len_reg < LEN_W'(avail_reg)) ? len_reg[SIZE_W-1:0] : avail_reg;
        n_key    = (take < SIZE_W'(8)) ? take : SIZE_W'(8);
        total    = kind_reg ? take : n_key;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop && is_query && (sz >= HDR_BYTES))
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (last_byte)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (idx_past || entry_out) ? S_IDLE : S_LEN;
            end
            S_LEN:
            begin
                if (last_byte)
                begin
                    state_next = (idx_reg == '0) ? S_POS : S_SUM;
                end
            end
            S_SUM:
            begin
                if (last_byte)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                state_next = pos_out ? S_IDLE : S_TAKE;
            end
            S_TAKE:
            begin
                state_next = (total == '0) ? S_IDLE : S_DATA;
            end
            S_DATA:
            begin
                if (last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        table_next      = table_reg;
        len_next        = len_reg;
        off_next        = off_reg;
        pos_next        = pos_reg;
        avail_next      = avail_reg;
        ptr_next        = ptr_reg;
        iss_left_next   = iss_left_reg;
        recv_left_next  = recv_left_reg;
        lane_next       = lane_reg;
        acc_next        = acc_reg;
        res_strobe_next = 1'b0;
        res_next        = res_reg;

        // byte stream: issue one read a cycle, collect one byte a cycle
        if (issue)
        begin
            ptr_next      = ptr_reg + 1'b1;
            iss_left_next = iss_left_reg - 1'b1;
        end
        if (rvld_reg)
        begin
            recv_left_next = recv_left_reg - 1'b1;
            lane_next      = lane_reg + 1'b1;
            acc_next       = acc_ins;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop && is_query)
                begin
                    kind_next = (q_item.op == OP_VALUE) ? KIND_VALUE : KIND_KEY;
                    idx_next  = q_item.idx;
                    if (sz < HDR_BYTES)
                    begin
                        res_strobe_next = 1'b1;
                        res_next        = '0;
                        res_next.kind   = (q_item.op == OP_VALUE) ? KIND_VALUE : KIND_KEY;
                        res_next.last   = 1'b1;
                        res_next.status = ST_RANGE;
                    end
                    else
                    begin
                        ptr_next       = '0;
                        iss_left_next  = HDR_BYTES;
                        recv_left_next = HDR_BYTES;
                        lane_next      = '0;
                        acc_next       = '0;
                    end
                end
            end
            S_CHECK:
            begin
                base_next  = base_full;
                table_next = tbl[ADDR_W-1:0];
                if (idx_past || entry_out)
                begin
                    res_strobe_next = 1'b1;
                    res_next        = '0;
                    res_next.kind   = kind_reg;
                    res_next.last   = 1'b1;
                    res_next.status = idx_past ? ST_INDEX : ST_RANGE;
                end
                else
                begin
                    ptr_next       = entry_addr[ADDR_W-1:0];
                    iss_left_next  = SIZE_W'(2);
                    recv_left_next = SIZE_W'(2);
                    lane_next      = '0;
                    acc_next       = '0;
                end
            end
            S_LEN:
            begin
                if (last_byte)
                begin
                    len_next = acc_ins[15:0];
                    off_next = '0;
                    // entry lies inside the block, so every earlier one does too
                    ptr_next       = table_reg;
                    iss_left_next  = {idx_reg[8:0], 1'b0};
                    recv_left_next = {idx_reg[8:0], 1'b0};
                    lane_next      = '0;
                    acc_next       = '0;
                end
            end
            S_SUM:
            begin
                if (rvld_reg)
                begin
                    off_next = off_reg + (lane_reg[0] ? {8'd0, rbyte, 8'd0}
                                                      : {16'd0, rbyte});
                end
            end
            S_POS:
            begin
                if (pos_out)
                begin
                    res_strobe_next = 1'b1;
                    res_next        = '0;
                    res_next.kind   = kind_reg;
                    res_next.last   = 1'b1;
                    res_next.status = ST_RANGE;
                end
                else
                begin
                    pos_next   = pos_full[SIZE_W-1:0];
                    avail_next = sz - pos_full[SIZE_W-1:0];
                end
            end
            S_TAKE:
            begin
                if (total == '0)
                begin
                    res_strobe_next       = 1'b1;
                    res_next              = '0;
                    res_next.kind         = kind_reg;
                    res_next.field_length = len_reg;
                    res_next.last         = 1'b1;
                    res_next.status       = ST_OK;
                end
                else
                begin
                    ptr_next       = pos_reg[ADDR_W-1:0];
                    iss_left_next  = total;
                    recv_left_next = total;
                    lane_next      = '0;
                    acc_next       = '0;
                end
            end
            S_DATA:
            begin
                if (rvld_reg && ((lane_reg == 3'd7) || (recv_left_reg == SIZE_W'(1))))
                begin
                    res_strobe_next       = 1'b1;
                    res_next.kind         = kind_reg;
                    res_next.word         = acc_ins;
                    res_next.byte_count   = {1'b0, lane_reg} + 4'd1;
                    res_next.field_length = len_reg;
                    res_next.last         = (recv_left_reg == SIZE_W'(1));
                    res_next.status       = ST_OK;
                    acc_next              = '0;
                end
            end
            default:
            begin
                res_strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rvld_reg       <= 1'b0;
            res_strobe_reg <= 1'b0;
            iss_left_reg   <= '0;
            recv_left_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rvld_reg       <= issue;
            res_strobe_reg <= res_strobe_next;
            iss_left_reg   <= iss_left_next;
            recv_left_reg  <= recv_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        table_reg <= table_next;
        len_reg   <= len_next;
        off_reg   <= off_next;
        pos_reg   <= pos_next;
        avail_reg <= avail_next;
        ptr_reg   <= ptr_next;
        lane_reg  <= lane_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

    `BRL_ASSERT_NOW(a_err_no_data, res_strobe_reg && (res_reg.status != ST_OK), (res_reg.word == '0) && (res_reg.byte_count == 4'd0) && res_reg.last, "error result carries data")
    `BRL_ASSERT_NOW(a_mid_chunk_full, res_strobe_reg && !res_reg.last, (res_reg.kind == KIND_VALUE) && (res_reg.byte_count == 4'd8), "non-final result is not a full value chunk")
    `BRL_ASSERT_NOW(a_read_in_stream, rvld_reg, (state_reg == S_HDR) || (state_reg == S_LEN) || (state_reg == S_SUM) || (state_reg == S_DATA), "read data returned outside a streaming state")
    `BRL_ASSERT_NEXT(a_query_starts, pop && (q_item.op != OP_LOAD), (state_reg == S_HDR) || (res_strobe_reg && (res_reg.status == ST_RANGE)), "popped query neither reads header nor fails")

endmodule
